[hw/rtl/b64dec_pkg.sv]
// ----------------------------------------------------------------------------
// b64dec_pkg
// Shared types, codes and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64dec_pkg;

    // Default width of the per-message byte counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Commands held between the front and the back
    localparam int QUEUE_DEPTH = 4;

    localparam int CAP_WIDTH = 16;
    localparam int LEN_WIDTH = 16;

    // Classifier codes beyond the 64 alphabet digits
    localparam logic [6:0] DIG_SKIP = 7'd64;
    localparam logic [6:0] DIG_PAD  = 7'd65;
    localparam logic [6:0] DIG_BAD  = 7'd66;

    // Input item kinds
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Report status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SMALL   = 2'd2;

    // One unit of work for the back: up to three bytes, then maybe a report.
    // Bytes are packed first byte in [23:16].
    typedef struct packed {
        logic [1:0]           n_bytes;
        logic [23:0]          bytes;
        logic                 has_report;
        logic [1:0]           status;
        logic [LEN_WIDTH-1:0] length;
    } cmd_t;

    // Queue flags seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [6:0] d;
        if (c >= 8'h41 && c <= 8'h5a) begin
            d = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            d = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            d = 7'd62;
        end else if (c == 8'h2f) begin
            d = 7'd63;
        end else if (c == 8'h0a) begin
            d = DIG_SKIP;
        end else if (c == 8'h3d) begin
            d = DIG_PAD;
        end else begin
            d = DIG_BAD;
        end
        return d;
    endfunction

endpackage

[hw/rtl/b64dec_front.sv]
// ----------------------------------------------------------------------------
// b64dec_front
// Classifies characters, gathers digits and tracks message state; issues
// byte and report commands to the queue.
// ----------------------------------------------------------------------------
module b64dec_front #(
    parameter int COUNT_WIDTH = b64dec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [b64dec_pkg::CAP_WIDTH-1:0]    output_capacity,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_func,
    input  logic [7:0]                          in_char,
    input  b64dec_pkg::queue_stat_t             qstat,
    output logic                                cmd_valid,
    output b64dec_pkg::cmd_t                    cmd
);
    import b64dec_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;
    localparam logic [CMP_W-1:0] MAX_COUNT = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [23:0]            buf_reg,   buf_next;
    logic [1:0]             cnt_reg,   cnt_next;
    logic [COUNT_WIDTH-1:0] bytes_reg, bytes_next;
    logic                   pad_reg,   pad_next;
    logic [1:0]             err_reg,   err_next;

    logic             accept;
    logic [6:0]       dig;
    logic [23:0]      group;
    logic [1:0]       need;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] sum;
    logic             over;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign dig      = classify(in_char);
    assign group    = {buf_reg[17:0], dig[5:0]};

    // Bytes that this item would release
    always_comb begin
        if (in_func == FUNC_CHAR) begin
            need = 2'd3;
        end else if (cnt_reg == 2'd3) begin
            need = 2'd2;
        end else if (cnt_reg == 2'd2) begin
            need = 2'd1;
        end else begin
            need = 2'd0;
        end
    end

    assign limit = (CMP_W'(output_capacity) < MAX_COUNT) ? CMP_W'(output_capacity) : MAX_COUNT;
    assign sum   = CMP_W'(bytes_reg) + CMP_W'(need);
    assign over  = sum > limit;

    always_comb begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        if (accept) begin
            if (in_func == FUNC_CHAR) begin
                if (err_reg == ST_OK && !pad_reg) begin
                    if (dig == DIG_SKIP) begin
                        buf_next = buf_reg;
                    end else if (dig == DIG_PAD) begin
                        pad_next = 1'b1;
                    end else if (dig == DIG_BAD) begin
                        err_next = ST_INVALID;
                    end else if (cnt_reg != 2'd3) begin
                        buf_next = group;
                        cnt_next = cnt_reg + 2'd1;
                    end else begin
                        buf_next = '0;
                        cnt_next = '0;
                        if (over) begin
                            err_next = ST_SMALL;
                        end else begin
                            bytes_next    = sum[COUNT_WIDTH-1:0];
                            cmd_valid     = 1'b1;
                            cmd.n_bytes   = 2'd3;
                            cmd.bytes     = group;
                        end
                    end
                end
            end else begin
                // End of message: flush a partial group, then report
                cmd_valid      = 1'b1;
                cmd.has_report = 1'b1;
                if (err_reg == ST_OK && need != 2'd0) begin
                    if (over) begin
                        err_next = ST_SMALL;
                    end else begin
                        bytes_next  = sum[COUNT_WIDTH-1:0];
                        cmd.n_bytes = need;
                        if (cnt_reg == 2'd3) begin
                            cmd.bytes = {buf_reg[17:2], 8'h00};
                        end else begin
                            cmd.bytes = {buf_reg[11:4], 16'h0000};
                        end
                    end
                end
                cmd.status = err_next;
                cmd.length = LEN_WIDTH'(CMP_W'(bytes_next));
                buf_next   = '0;
                cnt_next   = '0;
                bytes_next = '0;
                pad_next   = 1'b0;
                err_next   = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg   <= '0;
            cnt_reg   <= '0;
            bytes_reg <= '0;
            pad_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end else begin
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
        end
    end

endmodule

[hw/rtl/b64dec_queue.sv]
// ----------------------------------------------------------------------------
// b64dec_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module b64dec_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  b64dec_pkg::cmd_t        push_cmd,
    input  logic                    pop,
    output b64dec_pkg::cmd_t        head,
    output b64dec_pkg::queue_stat_t qstat
);
    import b64dec_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg,   fill_next;

    assign head        = mem[rd_ptr_reg];
    assign qstat.full  = fill_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign qstat.empty = fill_reg == '0;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hw/rtl/b64dec_back.sv]
// ----------------------------------------------------------------------------
// b64dec_back
// Splits each queued command into result requests, one per cycle while
// m_tready allows, into a registered output stage.
// ----------------------------------------------------------------------------
module b64dec_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  b64dec_pkg::cmd_t        head,
    input  b64dec_pkg::queue_stat_t qstat,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic [0:0]              m_tuser,
    output logic                    m_tlast
);
    import b64dec_pkg::*;

    logic [1:0]  beat_reg,  beat_next;
    logic        valid_reg, valid_next;
    logic [31:0] data_reg,  data_next;
    logic        user_reg,  user_next;
    logic        last_reg,  last_next;

    logic       advance;
    logic [1:0] last_beat;
    logic       is_last;
    logic [7:0] sel_byte;

    assign advance   = !valid_reg || m_tready;
    assign last_beat = head.n_bytes + 2'(head.has_report) - 2'd1;
    assign is_last   = beat_reg == last_beat;
    assign pop       = advance && !qstat.empty && is_last;

    always_comb begin
        case (beat_reg)
            2'd0:    sel_byte = head.bytes[23:16];
            2'd1:    sel_byte = head.bytes[15:8];
            default: sel_byte = head.bytes[7:0];
        endcase
    end

    always_comb begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = !qstat.empty;
            if (!qstat.empty) begin
                last_next = is_last;
                beat_next = is_last ? 2'd0 : beat_reg + 2'd1;
                if (beat_reg < head.n_bytes) begin
                    data_next = {24'h000000, sel_byte};
                    user_next = 1'b0;
                end else begin
                    data_next = {6'd0, head.length, head.status, 8'h00};
                    user_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

[hw/rtl/base64_decoder.sv]
// ----------------------------------------------------------------------------
// base64_decoder
// Base64 text decoder: one character per request in, decoded bytes and an
// end-of-message report out.
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle on the slave side while the
// queue has room, and returns decoded bytes on the master side, one result
// per cycle while m_tready is high. Every fourth alphabet digit releases
// three bytes; newlines are skipped, the first '=' ends the data and any
// other character flags invalid data and drops the rest of the message. A
// request with s_tuser set ends the message: held digits flush one or two
// bytes, followed by a report (m_tuser set) with the status and the byte
// count. A group that would exceed output_capacity is not emitted and the
// report says buffer too small. The front accepts a character every cycle
// while the four-entry command queue has room; the back drains one result
// per cycle, when not stalled, through an output register after the queue.
// An end of message with a partial group holds the queue head for up to
// three results. Write output_capacity only between messages.
// ----------------------------------------------------------------------------
module base64_decoder #(
    parameter int COUNT_WIDTH = b64dec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Capacity register write
    input  logic                             cfg_we,
    input  logic [b64dec_pkg::CAP_WIDTH-1:0] cfg_wdata,
    // Character input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] in_char
    input  logic [0:0]                       s_tuser,  // [0] func (1 = end of message)
    // Decoded output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,  // [7:0] out_byte, [9:8] status,
                                                       // [25:10] decoded_length, rest 0
    output logic [0:0]                       m_tuser,  // [0] is_report
    output logic                             m_tlast   // last result of the request
);
    import b64dec_pkg::*;

    logic [CAP_WIDTH-1:0] cap_reg;
    logic                 cmd_valid;
    cmd_t                 cmd;
    cmd_t                 head;
    queue_stat_t          qstat;
    logic                 pop;

    // Hold the capacity; reset to the full 16-bit range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '1;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Front: classify characters and advance the message state
    b64dec_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .output_capacity (cap_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_func         (s_tuser[0]),
        .in_char         (s_tdata),
        .qstat           (qstat),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd)
    );

    // Decouple the front from output stalls
    b64dec_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // Back: drop each command onto the output one result at a time
    b64dec_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[test/base64_decoder_test.sv]
// ----------------------------------------------------------------------------
// base64_decoder_test
// Self-checking testbench for the base64 decoder. A directed table covers the
// alphabet extremes, newline, padding, partial-group flushes, invalid bytes
// and the empty message; random messages then run under several capacities.
// Every accepted result is checked against a behavioral decoder or typed row.
// ----------------------------------------------------------------------------
module base64_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import b64dec_pkg::*;

    // Character codes with a meaning of their own
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_PAD     = 8'h3d;

    // The back registers its output, and an end of message flushing a partial
    // group yields up to three results. The settle wait covers anything still
    // in flight.
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
    localparam int PHASE_ITEMS   = 40;    // minimum random requests per capacity phase
    localparam int HOLD_PHASE    = 3;     // phase that runs the long hold-off

    // One decoded result as it leaves the block
    typedef struct packed {
        logic [7:0]           data;
        logic                 report;
        logic [1:0]           status;
        logic [LEN_WIDTH-1:0] length;
        logic                 last;
    } dec_result_t;

    // One row of the directed table; typed rows carry their report by hand
    typedef struct packed {
        logic                 func;
        logic [7:0]           ch;
        logic                 typed;
        logic [1:0]           status;
        logic [LEN_WIDTH-1:0] length;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    // Expected decoder output, oldest first
    dec_result_t dec_expect[$];
    // Results of the most recent request, before they are queued
    dec_result_t step_results[$];

    // Decoder model state
    logic [23:0]          held_bits  = '0;
    logic [1:0]           held_count = '0;
    logic [15:0]          msg_bytes  = '0;
    logic                 pad_hit    = 1'b0;
    logic [1:0]           msg_status = ST_OK;
    logic [CAP_WIDTH-1:0] byte_cap   = 16'hffff;

    int          mismatches = 0;
    int          chars_sent = 0;
    int          burst_left = 0;
    bit          drain_hold = 1'b0;
    dec_result_t seen_want;

    stim_row_t directed_rows [0:23] = '{
        // empty message right after reset
        '{FUNC_END,  8'h00,  1'b1, ST_OK,      16'd0},
        // alphabet extremes, a newline between two groups
        '{FUNC_CHAR, "A",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "Z",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "a",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "z",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, CH_NEWLINE, 1'b0, ST_OK,  16'd0},
        '{FUNC_CHAR, "0",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "9",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "+",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "/",    1'b0, ST_OK,      16'd0},
        // three held digits flush two bytes
        '{FUNC_CHAR, "Q",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "U",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "J",    1'b0, ST_OK,      16'd0},
        '{FUNC_END,  8'h00,  1'b0, ST_OK,      16'd0},
        // two digits then padding; a bad character after the pad is ignored
        '{FUNC_CHAR, "Y",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "g",    1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, CH_PAD, 1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "@",    1'b0, ST_OK,      16'd0},
        '{FUNC_END,  8'hff,  1'b0, ST_OK,      16'd0},
        // a lone digit is dropped
        '{FUNC_CHAR, "Q",    1'b0, ST_OK,      16'd0},
        '{FUNC_END,  8'h00,  1'b1, ST_OK,      16'd0},
        // a high byte is invalid and the digit after it is ignored
        '{FUNC_CHAR, 8'hff,  1'b0, ST_OK,      16'd0},
        '{FUNC_CHAR, "A",    1'b0, ST_OK,      16'd0},
        '{FUNC_END,  8'h00,  1'b1, ST_INVALID, 16'd0}
    };

    base64_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Map a character to its six-bit digit or to one of the special codes
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [6:0] v;
        v = DIG_BAD;
        if (c inside {[8'h41:8'h5a]}) v = 7'(c) - 7'd65;
        if (c inside {[8'h61:8'h7a]}) v = 7'(c) - 7'd71;
        if (c inside {[8'h30:8'h39]}) v = 7'(c) + 7'd4;
        if (c == 8'h2b)               v = 7'd62;
        if (c == 8'h2f)               v = 7'd63;
        if (c == CH_NEWLINE)          v = DIG_SKIP;
        if (c == CH_PAD)              v = DIG_PAD;
        return v;
    endfunction

    // Inverse mapping, used to build well-formed text
    function automatic logic [7:0] digit_char(input int unsigned v);
        if (v < 26) return 8'(65 + v);
        if (v < 52) return 8'(97 + v - 26);
        if (v < 62) return 8'(48 + v - 52);
        return (v == 62) ? 8'h2b : 8'h2f;
    endfunction

    function automatic void emit(input logic [7:0] data, input logic report,
                                 input logic [1:0] status, input logic [15:0] length,
                                 input logic last);
        step_results.push_back('{data, report, status, length, last});
    endfunction

    // True if n more bytes would push the message past the capacity
    function automatic bit over_cap(input int unsigned n);
        return (int'(msg_bytes) + n) > int'(byte_cap);
    endfunction

    // Advance the model by one request; its results land in step_results
    function automatic void decode_step(input logic func, input logic [7:0] ch);
        logic [6:0]  dig;
        logic [23:0] group;
        step_results.delete();
        if (func == FUNC_CHAR) begin
            if (msg_status != ST_OK || pad_hit) return;
            dig = char_value(ch);
            if (dig == DIG_SKIP) return;
            if (dig == DIG_PAD) begin
                pad_hit = 1'b1;
                return;
            end
            if (dig == DIG_BAD) begin
                msg_status = ST_INVALID;
                return;
            end
            if (held_count != 2'd3) begin
                held_bits  = {held_bits[17:0], dig[5:0]};
                held_count = held_count + 2'd1;
                return;
            end
            // fourth digit completes the group
            group      = {held_bits[17:0], dig[5:0]};
            held_bits  = '0;
            held_count = '0;
            if (over_cap(3)) begin
                msg_status = ST_SMALL;
                return;
            end
            msg_bytes = msg_bytes + 16'd3;
            emit(group[23:16], 1'b0, ST_OK, '0, 1'b0);
            emit(group[15:8],  1'b0, ST_OK, '0, 1'b0);
            emit(group[7:0],   1'b0, ST_OK, '0, 1'b1);
            return;
        end
        // end of message: flush a partial group unless an error is pending
        if (msg_status == ST_OK && held_count == 2'd3) begin
            if (over_cap(2)) begin
                msg_status = ST_SMALL;
            end else begin
                msg_bytes = msg_bytes + 16'd2;
                emit(held_bits[17:10], 1'b0, ST_OK, '0, 1'b0);
                emit(held_bits[9:2],   1'b0, ST_OK, '0, 1'b0);
            end
        end else if (msg_status == ST_OK && held_count == 2'd2) begin
            if (over_cap(1)) begin
                msg_status = ST_SMALL;
            end else begin
                msg_bytes = msg_bytes + 16'd1;
                emit(held_bits[11:4], 1'b0, ST_OK, '0, 1'b0);
            end
        end
        emit(8'h00, 1'b1, msg_status, msg_bytes, 1'b1);
        held_bits  = '0;
        held_count = '0;
        msg_bytes  = '0;
        pad_hit    = 1'b0;
        msg_status = ST_OK;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one request and hold it until accepted. The sender runs in bursts
    // of random length; between bursts it may drop tvalid for a random gap.
    task automatic send_req(input logic func, input logic [7:0] ch,
                            input logic typed = 1'b0, input logic [1:0] status = ST_OK,
                            input logic [15:0] length = '0);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= ch;
        s_tuser[0] <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        chars_sent++;
        // predict right at acceptance, before any result can come back
        decode_step(func, ch);
        if (typed) begin
            dec_expect.push_back('{8'h00, 1'b1, status, length, 1'b1});
        end else begin
            foreach (step_results[i]) dec_expect.push_back(step_results[i]);
        end
    endtask

    task automatic send_digit();
        if ($urandom_range(0, 9) == 0) send_req(FUNC_CHAR, CH_NEWLINE);
        send_req(FUNC_CHAR, digit_char($urandom_range(0, 63)));
    endtask

    // One random message: mostly well-formed text, sometimes noise
    task automatic send_message();
        int kind;
        int groups;
        int tail;
        int n;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            groups = $urandom_range(0, 3);
            for (int i = 0; i < groups * 4; i++) send_digit();
            tail = $urandom_range(0, 3);
            for (int i = 0; i < tail; i++) send_digit();
            if (tail >= 2 && $urandom_range(0, 1) == 1) begin
                send_req(FUNC_CHAR, CH_PAD);
                if (tail == 2 && $urandom_range(0, 1) == 1) send_req(FUNC_CHAR, CH_PAD);
                // anything after the pad is ignored
                if ($urandom_range(0, 2) == 0) send_req(FUNC_CHAR, 8'($urandom_range(0, 255)));
            end
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_req(FUNC_CHAR, digit_char($urandom_range(0, 63)));
                end else begin
                    send_req(FUNC_CHAR, 8'($urandom_range(0, 255)));
                end
            end
        end
        // in_char is a don't-care on the end of message; toggle it anyway
        send_req(FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    // Hold the sender until every expected result is back, then let any
    // request without results drain out of the block
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (dec_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cap(input logic [CAP_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        byte_cap = value;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: stall patterns, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int span;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (drain_hold) begin
                // hold off long enough for the command queue to fill and
                // back-pressure the sender
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                drain_hold = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 40);
            // cut the pattern short as soon as a hold-off is requested
            for (int i = 0; i < span && !drain_hold; i++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (i % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (dec_expect.size() == 0) begin
                flag_mismatch("result with nothing expected", m_tdata, 0);
            end else begin
                seen_want = dec_expect.pop_front();
                if (m_tdata[7:0] != seen_want.data)
                    flag_mismatch("out_byte", m_tdata[7:0], seen_want.data);
                if (m_tuser[0] != seen_want.report)
                    flag_mismatch("is_report", m_tuser[0], seen_want.report);
                if (m_tdata[9:8] != seen_want.status)
                    flag_mismatch("status", m_tdata[9:8], seen_want.status);
                if (m_tdata[25:10] != seen_want.length)
                    flag_mismatch("decoded_length", m_tdata[25:10], seen_want.length);
                if (m_tlast != seen_want.last)
                    flag_mismatch("last", m_tlast, seen_want.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_caps [5];
        int          mark;
        // zero and tiny capacities force buffer-too-small; full range while
        // the receiver holds off
        phase_caps = '{0, 4, 0, 65535, 7};
        phase_caps[2] = $urandom_range(0, 65535);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at the reset capacity
        foreach (directed_rows[r]) begin
            send_req(directed_rows[r].func, directed_rows[r].ch, directed_rows[r].typed,
                     directed_rows[r].status, directed_rows[r].length);
        end

        // random messages, one capacity setting per phase
        foreach (phase_caps[p]) begin
            settle();
            write_cap(phase_caps[p]);
            if (p == HOLD_PHASE) drain_hold = 1'b1;
            mark = chars_sent;
            while (chars_sent < mark + PHASE_ITEMS) send_message();
        end

        settle();
        if (mismatches == 0 && dec_expect.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/b64dec_pkg.sv
hw/rtl/b64dec_front.sv
hw/rtl/b64dec_queue.sv
hw/rtl/b64dec_back.sv
hw/rtl/base64_decoder.sv
test/base64_decoder_test.sv
